[rtl/core/scaled_pair_frame_crc8_encoder_core_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the scaled pair frame encoder
// Shared property forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef SCALED_PAIR_FRAME_CRC8_ENCODER_CORE_MACROS_SVH
`define SCALED_PAIR_FRAME_CRC8_ENCODER_CORE_MACROS_SVH

// Same-cycle implication, ignored while reset is held.
`define SPFC8_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, ignored while reset is held.
`define SPFC8_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that is checked during reset too.
`define SPFC8_ASSERT_NXT_ALL(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/spfc8_pkg.sv]
// ----------------------------------------------------------------------------
// spfc8_pkg
// Types, constants and the CRC-8 byte update for the scaled pair framer.
// ----------------------------------------------------------------------------
package spfc8_pkg;

    localparam int COEF_W = 32;

    localparam logic [7:0] FRAME_FLAG = 8'h7E;
    localparam logic [7:0] CRC_POLY   = 8'h31;
    localparam logic [7:0] CRC_INIT   = 8'hFF;
    localparam logic [7:0] CRC_TOP    = 8'h80;

    // Configuration register indexes
    localparam logic [1:0] REG_SERVO_GAIN   = 2'd0;
    localparam logic [1:0] REG_SERVO_OFFSET = 2'd1;
    localparam logic [1:0] REG_STEP_GAIN    = 2'd2;
    localparam logic [1:0] REG_STEP_OFFSET  = 2'd3;

    // Reset values of the coefficients (Q15.16)
    localparam logic signed [COEF_W-1:0] GAIN_RESET   = -32'sd4063;
    localparam logic signed [COEF_W-1:0] OFFSET_RESET = 32'sd16711680;

    // Positions within the six-byte frame
    localparam logic [2:0] IDX_OPEN   = 3'd0;
    localparam logic [2:0] IDX_SERVO  = 3'd1;
    localparam logic [2:0] IDX_STEP   = 3'd2;
    localparam logic [2:0] IDX_STATUS = 3'd3;
    localparam logic [2:0] IDX_CRC    = 3'd4;
    localparam logic [2:0] IDX_CLOSE  = 3'd5;

    typedef struct packed {
        logic [7:0] servo;
        logic [7:0] step;
        logic [7:0] status;
    } frame_payload_t;

    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if ((c & CRC_TOP) != 8'h00) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

    // CRC state after the opening flag, which never changes
    localparam logic [7:0] CRC_AFTER_OPEN = crc8_byte(CRC_INIT, FRAME_FLAG);

endpackage

[rtl/core/spfc8_scale.sv]
// ----------------------------------------------------------------------------
// spfc8_scale
// One channel: registered gain * sample, then add offset, truncate, saturate.
// ----------------------------------------------------------------------------
module spfc8_scale #(
    parameter int SAMPLE_BITS    = 12,
    parameter int COEF_FRAC_BITS = 16
) (
    input  logic                                   aclk,
    input  logic                                   en,
    input  logic [SAMPLE_BITS-1:0]                 sample,
    input  logic signed [spfc8_pkg::COEF_W-1:0]    gain,
    input  logic signed [spfc8_pkg::COEF_W-1:0]    offset,
    output logic [7:0]                             byte_out
);

    localparam int PROD_W = spfc8_pkg::COEF_W + SAMPLE_BITS + 1;
    localparam int SUM_W  = PROD_W + 1;

    logic signed [SAMPLE_BITS:0] sample_s;
    logic signed [PROD_W-1:0]    product_next;
    logic signed [PROD_W-1:0]    product_reg;
    logic signed [SUM_W-1:0]     sum;

    assign sample_s     = signed'({1'b0, sample});
    assign product_next = gain * sample_s;

    always_ff @(posedge aclk) begin
        if (en) begin
            product_reg <= product_next;
        end
    end

    assign sum = signed'({product_reg[PROD_W-1], product_reg})
               + signed'({{(SUM_W-spfc8_pkg::COEF_W){offset[spfc8_pkg::COEF_W-1]}}, offset});

    // Negative clamps to zero, anything past 255 clamps to full scale
    always_comb begin
        if (sum[SUM_W-1]) begin
            byte_out = 8'h00;
        end else if (|sum[SUM_W-2:COEF_FRAC_BITS+8]) begin
            byte_out = 8'hFF;
        end else begin
            byte_out = sum[COEF_FRAC_BITS+7:COEF_FRAC_BITS];
        end
    end

endmodule

[rtl/core/spfc8_framer.sv]
// ----------------------------------------------------------------------------
// spfc8_framer
// Holds one frame payload and sends the six frame bytes, folding each of
// the three payload bytes into the CRC as it is sent.
// ----------------------------------------------------------------------------
module spfc8_framer (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       load,
    input  spfc8_pkg::frame_payload_t  payload,
    output logic                       load_ready,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [7:0]                 m_tdata,
    output logic                       m_tlast
);

    logic                      busy_reg, busy_next;
    logic [2:0]                idx_reg, idx_next;
    logic [7:0]                crc_reg, crc_next;
    spfc8_pkg::frame_payload_t payload_reg;
    logic                      out_hs;

    assign out_hs     = busy_reg && m_tready;
    assign load_ready = !busy_reg || (out_hs && idx_reg == spfc8_pkg::IDX_CLOSE);

    always_comb begin
        case (idx_reg)
            spfc8_pkg::IDX_OPEN:   m_tdata = spfc8_pkg::FRAME_FLAG;
            spfc8_pkg::IDX_SERVO:  m_tdata = payload_reg.servo;
            spfc8_pkg::IDX_STEP:   m_tdata = payload_reg.step;
            spfc8_pkg::IDX_STATUS: m_tdata = payload_reg.status;
            spfc8_pkg::IDX_CRC:    m_tdata = crc_reg;
            default:               m_tdata = spfc8_pkg::FRAME_FLAG;
        endcase
    end

    assign m_tvalid = busy_reg;
    assign m_tlast  = (idx_reg == spfc8_pkg::IDX_CLOSE);

    always_comb begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        crc_next  = crc_reg;
        if (load) begin
            busy_next = 1'b1;
            idx_next  = spfc8_pkg::IDX_OPEN;
            crc_next  = spfc8_pkg::CRC_AFTER_OPEN;
        end else if (out_hs) begin
            if (idx_reg == spfc8_pkg::IDX_CLOSE) begin
                busy_next = 1'b0;
            end else begin
                idx_next = idx_reg + 3'd1;
            end
            // fold in the three payload bytes as they leave
            if (idx_reg == spfc8_pkg::IDX_SERVO || idx_reg == spfc8_pkg::IDX_STEP
                || idx_reg == spfc8_pkg::IDX_STATUS) begin
                crc_next = spfc8_pkg::crc8_byte(crc_reg, m_tdata);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            idx_reg  <= spfc8_pkg::IDX_OPEN;
        end else begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        crc_reg <= crc_next;
        if (load) begin
            payload_reg <= payload;
        end
    end

endmodule

[rtl/core/scaled_pair_frame_crc8_encoder_core.sv]
// ----------------------------------------------------------------------------
// scaled_pair_frame_crc8_encoder_core
// Scales two joystick samples to bytes and sends them as a CRC-8 frame.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one transaction carries servo sample, step sample and status.
//   m_ channel: each input yields six transactions of one byte each:
//     0x7E, servo byte, step byte, status, CRC-8 (0x31, init 0xFF), 0x7E.
//     m_tlast marks the closing 0x7E.
//   cfg port: write gain/offset registers (Q15.16) while the block is idle.
// Path: the input transaction goes through the input register, the
//   multiplier register and the frame register to the first byte on m_tdata.
// Output rate: one byte per cycle while m_tready is high; the next frame
//   follows the last byte with no gap.
// Reset: coefficients return to gain -4063/65536 and offset 255.0, the pipeline
//   empties and m_tvalid drops.
// Stall: m_tdata/m_tlast hold while m_tready is low; up to two more items
//   are taken into the pipeline, then s_tready drops.
// ----------------------------------------------------------------------------
module scaled_pair_frame_crc8_encoder_core #(
    parameter int SAMPLE_BITS    = 12,
    parameter int COEF_FRAC_BITS = 16
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    // s_tdata: servo_sample, step_sample, status_byte (lowest bit up)
    input  logic [((2*SAMPLE_BITS+8+7)/8)*8-1:0] s_tdata,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    // m_tdata: frame_byte
    output logic [7:0]              m_tdata,
    output logic                    m_tlast,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    input  logic                    cfg_wr_en,
    input  logic [1:0]              cfg_index,
    input  logic [31:0]             cfg_wdata
);

    logic signed [31:0] servo_gain_reg, servo_offset_reg;
    logic signed [31:0] step_gain_reg, step_offset_reg;

    logic [SAMPLE_BITS-1:0] servo_in_reg, step_in_reg;
    logic [7:0]             status_in_reg, status_p2_reg;
    logic                   v1_reg, v1_next, v2_reg, v2_next;

    logic s_hs, adv2, load, load_ready;
    logic [7:0] servo_byte, step_byte;
    spfc8_pkg::frame_payload_t payload;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            servo_gain_reg   <= spfc8_pkg::GAIN_RESET;
            servo_offset_reg <= spfc8_pkg::OFFSET_RESET;
            step_gain_reg    <= spfc8_pkg::GAIN_RESET;
            step_offset_reg  <= spfc8_pkg::OFFSET_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                spfc8_pkg::REG_SERVO_GAIN:   servo_gain_reg   <= signed'(cfg_wdata);
                spfc8_pkg::REG_SERVO_OFFSET: servo_offset_reg <= signed'(cfg_wdata);
                spfc8_pkg::REG_STEP_GAIN:    step_gain_reg    <= signed'(cfg_wdata);
                spfc8_pkg::REG_STEP_OFFSET:  step_offset_reg  <= signed'(cfg_wdata);
                default: ;
            endcase
        end
    end

    // Pipeline handshake: each stage advances when the next one frees up
    assign load     = v2_reg && load_ready;
    assign adv2     = v1_reg && (!v2_reg || load);
    assign s_tready = !v1_reg || !v2_reg || load;
    assign s_hs     = s_tvalid && s_tready;

    always_comb begin
        v1_next = v1_reg;
        if (s_hs) begin
            v1_next = 1'b1;
        end else if (adv2) begin
            v1_next = 1'b0;
        end
        v2_next = v2_reg;
        if (adv2) begin
            v2_next = 1'b1;
        end else if (load) begin
            v2_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_hs) begin
            servo_in_reg  <= s_tdata[SAMPLE_BITS-1:0];
            step_in_reg   <= s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
            status_in_reg <= s_tdata[2*SAMPLE_BITS+7:2*SAMPLE_BITS];
        end
        if (adv2) begin
            status_p2_reg <= status_in_reg;
        end
    end

    spfc8_scale #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_servo_scale (
        .aclk     (aclk),
        .en       (adv2),
        .sample   (servo_in_reg),
        .gain     (servo_gain_reg),
        .offset   (servo_offset_reg),
        .byte_out (servo_byte)
    );

    spfc8_scale #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_step_scale (
        .aclk     (aclk),
        .en       (adv2),
        .sample   (step_in_reg),
        .gain     (step_gain_reg),
        .offset   (step_offset_reg),
        .byte_out (step_byte)
    );

    assign payload.servo  = servo_byte;
    assign payload.step   = step_byte;
    assign payload.status = status_p2_reg;

    spfc8_framer u_framer (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (load),
        .payload    (payload),
        .load_ready (load_ready),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule

[rtl/core/spfc8_checker.sv]
// ----------------------------------------------------------------------------
// spfc8_checker
// Port-level checks on the frame output of the encoder core.
// ----------------------------------------------------------------------------
`include "scaled_pair_frame_crc8_encoder_core_macros.svh"

module spfc8_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast
);

    `SPFC8_ASSERT_NXT_ALL(a_reset_idle, aclk, !aresetn, !m_tvalid, "output valid after reset")

    `SPFC8_ASSERT_IMP(a_close_flag, aclk, aresetn, m_tvalid && m_tlast, m_tdata == spfc8_pkg::FRAME_FLAG, "closing byte is not the flag")

    `SPFC8_ASSERT_NXT(a_open_after_close, aclk, aresetn, m_tvalid && m_tready && m_tlast, !m_tvalid || (m_tdata == spfc8_pkg::FRAME_FLAG && !m_tlast), "frame does not open with the flag")

    `SPFC8_ASSERT_NXT(a_stall_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "output changed while stalled")

endmodule

bind scaled_pair_frame_crc8_encoder_core spfc8_checker u_spfc8_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

[bench/scaled_pair_frame_crc8_encoder_core_test.sv]
// ----------------------------------------------------------------------------
// scaled_pair_frame_crc8_encoder_core_test
// Self-checking bench for the joystick pair framer. Each input transaction
// is scaled on the bench side to two bytes and packed into a six-byte
// CRC-8 frame. The frame is queued and compared byte by byte, with the
// last marker, against the m_ channel. Coefficients are rewritten between
// phases while the block is idle. Both channels stall at random.
// ----------------------------------------------------------------------------
module scaled_pair_frame_crc8_encoder_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SAMPLE_W     = 12;
    localparam int FRAC_W       = 16;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 8;

    typedef struct {
        logic [SAMPLE_W-1:0] servo;
        logic [SAMPLE_W-1:0] step;
        logic [7:0]          status;
    } joy_item_t;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } frame_beat_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic [31:0] s_tdata   = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [31:0] cfg_wdata = '0;

    // Coefficients as the bench believes the block holds them
    logic signed [31:0] servo_gain_q   = spfc8_pkg::GAIN_RESET;
    logic signed [31:0] servo_offset_q = spfc8_pkg::OFFSET_RESET;
    logic signed [31:0] step_gain_q    = spfc8_pkg::GAIN_RESET;
    logic signed [31:0] step_offset_q  = spfc8_pkg::OFFSET_RESET;

    joy_item_t   pending_q[$];
    frame_beat_t frame_byte_q[$];
    joy_item_t   sent_item;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          mismatch_count = 0;
    int          stall_cycles = 0;

    scaled_pair_frame_crc8_encoder_core #(
        .SAMPLE_BITS   (SAMPLE_W),
        .COEF_FRAC_BITS(FRAC_W)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // gain * sample + offset, exact in 64 bits, then truncate and clamp
    function automatic logic [7:0] scale_to_byte(input logic signed [31:0] gain,
                                                 input logic signed [31:0] offset,
                                                 input logic [SAMPLE_W-1:0] sample);
        longint acc;
        acc = longint'(gain) * longint'({1'b0, sample}) + longint'(offset);
        if (acc < 0) begin
            return 8'h00;
        end
        acc = acc >>> FRAC_W;
        if (acc > 255) begin
            return 8'hFF;
        end
        return acc[7:0];
    endfunction

    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] r;
        r = crc ^ b;
        repeat (8) begin
            r = r[7] ? ((r << 1) ^ spfc8_pkg::CRC_POLY) : (r << 1);
        end
        return r;
    endfunction

    function automatic void predict_frame(input joy_item_t it);
        logic [7:0] body[4];
        logic [7:0] crc;
        body[0] = spfc8_pkg::FRAME_FLAG;
        body[1] = scale_to_byte(servo_gain_q, servo_offset_q, it.servo);
        body[2] = scale_to_byte(step_gain_q, step_offset_q, it.step);
        body[3] = it.status;
        crc = spfc8_pkg::CRC_INIT;
        foreach (body[i]) begin
            crc = crc8_update(crc, body[i]);
            frame_byte_q.push_back('{data: body[i], last: 1'b0});
        end
        frame_byte_q.push_back('{data: crc, last: 1'b0});
        frame_byte_q.push_back('{data: spfc8_pkg::FRAME_FLAG, last: 1'b1});
    endfunction

    task automatic report_mismatch(input string what, input int exp_val, input int got_val);
        $display("%0t: %s expected %0h got %0h", $realtime, what, exp_val, got_val);
        mismatch_count++;
    endtask

    // Driver: hold the item until the handshake, then load the next one
    always @(posedge aclk) begin : drive_proc
        joy_item_t nxt;
        logic      load;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_frame(sent_item);
            end
            load = (!s_tvalid || s_tready) && (pending_q.size() > 0) &&
                   ($urandom_range(99) >= send_idle_pct);
            if (load) begin
                nxt = pending_q.pop_front();
                sent_item = nxt;
                s_tdata  <= {nxt.status, nxt.step, nxt.servo};
                s_tvalid <= 1'b1;
            end else if (s_tvalid && s_tready) begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Monitor: compare each transaction with the oldest expected byte
    always @(posedge aclk) begin : check_proc
        frame_beat_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (frame_byte_q.size() == 0) begin
                report_mismatch("unexpected frame byte", 0, m_tdata);
            end else begin
                want = frame_byte_q.pop_front();
                if (m_tdata !== want.data) begin
                    report_mismatch("frame byte", want.data, m_tdata);
                end
                if (m_tlast !== want.last) begin
                    report_mismatch("last marker", want.last, m_tlast);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic write_coef(input logic [1:0] idx, input logic [31:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            spfc8_pkg::REG_SERVO_GAIN:   servo_gain_q   = val;
            spfc8_pkg::REG_SERVO_OFFSET: servo_offset_q = val;
            spfc8_pkg::REG_STEP_GAIN:    step_gain_q    = val;
            spfc8_pkg::REG_STEP_OFFSET:  step_offset_q  = val;
            default: ;
        endcase
    endtask

    task automatic load_coefs(input logic [31:0] sg, input logic [31:0] so,
                              input logic [31:0] tg, input logic [31:0] to);
        write_coef(spfc8_pkg::REG_SERVO_GAIN, sg);
        write_coef(spfc8_pkg::REG_SERVO_OFFSET, so);
        write_coef(spfc8_pkg::REG_STEP_GAIN, tg);
        write_coef(spfc8_pkg::REG_STEP_OFFSET, to);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    // Wait until every frame is out, then let the pipeline settle
    task automatic wait_drained(input int settle);
        do begin
            @(negedge aclk);
        end while (pending_q.size() != 0 || s_tvalid || frame_byte_q.size() != 0);
        repeat (settle) @(negedge aclk);
    endtask

    task automatic push_item(input int sv, input int st, input int stat);
        pending_q.push_back('{servo: sv[SAMPLE_W-1:0], step: st[SAMPLE_W-1:0],
                              status: stat[7:0]});
    endtask

    function automatic logic [31:0] pick_extreme();
        case ($urandom_range(3))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    // Mostly gains that map the sample range onto at most about +/-1024 counts
    function automatic logic [31:0] pick_gain();
        case ($urandom_range(5))
            0: return pick_extreme();
            1: return $urandom();
            default: return 32'($signed($urandom_range(32768)) - 16384);
        endcase
    endfunction

    function automatic logic [31:0] pick_offset();
        case ($urandom_range(5))
            0: return pick_extreme();
            1: return $urandom();
            default: return 32'($signed($urandom_range(384 * 65536)) - 64 * 65536);
        endcase
    endfunction

    function automatic int pick_sample();
        if ($urandom_range(7) == 0) begin
            case ($urandom_range(3))
                0: return 0;
                1: return 1;
                2: return 4094;
                default: return 4095;
            endcase
        end
        return $urandom_range(4095);
    endfunction

    initial begin
        send_idle_pct = 6;
        recv_idle_pct = 81;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        wait_drained(4);

        // Reset coefficients: full scale lands near 1, zero at 255
        push_item(0, 0, 8'h00);
        push_item(4095, 4095, 8'hFF);
        push_item(12'hAAA, 12'h555, 8'h5A);
        push_item(12'h555, 12'hAAA, 8'hA5);
        push_item(2048, 1, 8'h7E);
        push_item(1, 2048, 8'h01);
        wait_drained(4);

        // Extreme coefficients: sums far below zero, just below zero and far above 255
        load_coefs(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
        push_item(0, 0, 8'h80);
        push_item(1, 1, 8'h7F);
        push_item(2, 2, 8'h00);
        push_item(4095, 4095, 8'hFF);
        wait_drained(4);

        // Unity gain on servo, half gain minus one half on step
        load_coefs(32'h0001_0000, 32'h0000_0000, 32'h0000_8000, 32'hFFFF_8000);
        push_item(200, 0, 8'h3C);
        push_item(255, 1, 8'hC3);
        push_item(256, 3, 8'h0F);
        push_item(4095, 4095, 8'hF0);
        push_item(0, 2, 8'h7D);
        wait_drained(4);

        for (int mode = 0; mode < 3; mode++) begin
            case (mode)
                0: begin
                    send_idle_pct = 6;
                    recv_idle_pct = 81;
                end
                1: begin
                    send_idle_pct = 81;
                    recv_idle_pct = 6;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int phase = 0; phase < 5; phase++) begin
                load_coefs(pick_gain(), pick_offset(), pick_gain(), pick_offset());
                repeat (20) begin
                    push_item(pick_sample(), pick_sample(), $urandom_range(255));
                end
                // Sender holds off here until the last frame has drained
                wait_drained(4);
            end
        end

        wait_drained(DRAIN_CYCLES);
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/spfc8_pkg.sv
rtl/core/spfc8_scale.sv
rtl/core/spfc8_framer.sv
rtl/core/scaled_pair_frame_crc8_encoder_core.sv
rtl/core/spfc8_checker.sv
bench/scaled_pair_frame_crc8_encoder_core_test.sv
